// ===== rtl/nfapsm_pkg.sv =====
// nfapsm_pkg: types and codes shared by the position-set matcher and its checker
// depends on nothing
package nfapsm_pkg;

  localparam int unsigned MaskW   = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    OP_LOAD_CLASS  = 2'd0,
    OP_LOAD_FOLLOW = 2'd1,
    OP_START       = 2'd2,
    OP_MATCH       = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_SET  = 1'd0,
    CFG_ACCEPT_SET = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_SWEEP,
    ST_REPORT
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [ByteW-1:0] table_index;
    logic [MaskW-1:0] table_data;
    logic [ByteW-1:0] symbol;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic matched;
    logic dead;
  } out_beat_t;

endpackage

// ===== rtl/nfa_position_set_matcher_unit.sv =====
// nfa_position_set_matcher_unit: top level, byte-class and follow memories with sweep control
// depends on nfapsm_pkg
//
// Simulates a position NFA over a set of up to NUM_STATES active positions. Load beats write
// the byte-class memory (256 rows) or the follow memory (NUM_STATES rows) and take effect for
// the next beat. A start beat copies start_set into the active set. A match beat on a nonempty
// set stalls the input until its sweep is done: the byte-class row is read at acceptance,
// the hit mask is formed, one follow row is read per cycle through the single read port of
// the follow memory, the read of the last row completes and is folded in, and the block
// returns to idle to take the next beat. A match beat on an empty set skips the sweep. A start
// or match beat marked last then loads the result register, waiting while an earlier result
// still sits there; the register holds the matched and dead flags until taken, and a new beat
// is accepted while it waits.
// Memories come up undefined and need no clearing pass; reading a row never written gives an
// undefined result.
module nfa_position_set_matcher_unit #(
  parameter int unsigned NUM_STATES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nfapsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [nfapsm_pkg::MaskW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nfapsm_pkg::in_beat_t          in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nfapsm_pkg::out_beat_t         out_beat_o
);
  import nfapsm_pkg::*;

  localparam int unsigned N  = NUM_STATES;
  localparam int unsigned PW = $clog2(N);
  localparam logic [ByteW-1:0] NumStatesIdx = ByteW'(N);
  localparam logic [PW-1:0]    LastPtr      = PW'(N - 1);

  logic [N-1:0] cls_mem [256];
  logic [N-1:0] fol_mem [N];
  logic [N-1:0] cls_rdata_q;
  logic [N-1:0] fol_rdata_q;

  state_e       state_q, state_d;
  logic [N-1:0] start_q, accept_q;
  logic [N-1:0] active_q, active_d;
  logic [N-1:0] hit_q, hit_d;
  logic [N-1:0] next_q, next_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic         issue_done_q, issue_done_d;
  logic         rd_vld_q, rd_vld_d;
  logic         last_q, last_d;
  logic         out_valid_q, out_valid_d;
  out_beat_t    out_beat_q, out_beat_d;

  logic         in_acc;
  logic         cls_we, cls_re, fol_we, fol_re;
  logic         out_free;
  logic [N-1:0] fol_term;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  assign cls_we = in_acc && (in_beat_i.operation == OP_LOAD_CLASS);
  assign cls_re = in_acc && (in_beat_i.operation == OP_MATCH);
  assign fol_we = in_acc && (in_beat_i.operation == OP_LOAD_FOLLOW)
                  && (in_beat_i.table_index < NumStatesIdx);
  assign fol_re = (state_q == ST_SWEEP) && !issue_done_q;
  assign fol_term = hit_q[0] ? fol_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (cls_we) begin
      cls_mem[in_beat_i.table_index] <= in_beat_i.table_data[N-1:0];
    end
    if (cls_re) begin
      cls_rdata_q <= cls_mem[in_beat_i.symbol];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fol_we) begin
      fol_mem[in_beat_i.table_index[PW-1:0]] <= in_beat_i.table_data[N-1:0];
    end
    if (fol_re) begin
      fol_rdata_q <= fol_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      accept_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_SET:  start_q  <= cfg_wdata_i[N-1:0];
        CFG_ACCEPT_SET: accept_q <= cfg_wdata_i[N-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_beat_i.operation)
            OP_START: state_d = in_beat_i.last ? ST_REPORT : ST_IDLE;
            OP_MATCH: begin
              if (active_q != '0) state_d = ST_CLASS;
              else                state_d = in_beat_i.last ? ST_REPORT : ST_IDLE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLASS: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (issue_done_q && rd_vld_q) state_d = last_q ? ST_REPORT : ST_IDLE;
      end
      ST_REPORT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    active_d     = active_q;
    hit_d        = hit_q;
    next_d       = next_q;
    rd_ptr_d     = rd_ptr_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    last_d       = last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_beat_d   = out_beat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          last_d = in_beat_i.last;
          if (in_beat_i.operation == OP_START) active_d = start_q;
        end
      end
      ST_CLASS: begin
        hit_d        = active_q & cls_rdata_q;
        next_d       = '0;
        rd_ptr_d     = '0;
        issue_done_d = 1'b0;
      end
      ST_SWEEP: begin
        if (!issue_done_q) begin
          rd_vld_d = 1'b1;
          if (rd_ptr_q == LastPtr) issue_done_d = 1'b1;
          else                     rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (rd_vld_q) begin
          next_d = next_q | fol_term;
          hit_d  = hit_q >> 1;
          if (issue_done_q) active_d = next_q | fol_term;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_beat_d.matched = |(active_q & accept_q);
          out_beat_d.dead    = ~|active_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      active_q     <= '0;
      rd_vld_q     <= 1'b0;
      issue_done_q <= 1'b0;
      rd_ptr_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      rd_vld_q     <= rd_vld_d;
      issue_done_q <= issue_done_d;
      rd_ptr_q     <= rd_ptr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q      <= hit_d;
    next_q     <= next_d;
    last_q     <= last_d;
    out_beat_q <= out_beat_d;
  end

endmodule

// ===== rtl/nfapsm_checker.sv =====
// nfapsm_checker: port-level assertions for the position-set matcher, bound to the top level
// depends on nfapsm_pkg and nfa_position_set_matcher_unit
module nfapsm_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input nfapsm_pkg::in_beat_t  in_beat_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input nfapsm_pkg::out_beat_t out_beat_o
);
  import nfapsm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o
    && (in_beat_i.operation == OP_LOAD_CLASS || in_beat_i.operation == OP_LOAD_FOLLOW)
    |=> !out_valid_o)
    else $error("load beat produced a result");

  a_empty_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_beat_i.operation == OP_START && in_beat_i.last |=> in_stall_o)
    else $error("empty string start did not hold input for its result");

  a_dead_not_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.dead |-> !out_beat_o.matched)
    else $error("empty set reported as match");

endmodule

bind nfa_position_set_matcher_unit nfapsm_checker u_nfapsm_checker (.*);

// ===== tb/tb_nfa_position_set_matcher_unit.sv =====
// tb_nfa_position_set_matcher_unit: self-checking bench for the position-set nfa matcher
// loads both tables, runs a directed table then random strings, checks against a local predictor
// depends on nfapsm_pkg and nfa_position_set_matcher_unit
module tb_nfa_position_set_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import nfapsm_pkg::*;

  localparam int unsigned NumPos = 64;
  localparam logic [63:0] PosMask = (NumPos >= 64) ? '1 : ((64'd1 << NumPos) - 64'd1);
  localparam logic [63:0] MaskAll = '1;
  localparam logic [63:0] MaskTop = 64'h8000_0000_0000_0000;

  localparam out_beat_t WantDead = '{matched: 1'b0, dead: 1'b1};
  localparam out_beat_t WantHit  = '{matched: 1'b1, dead: 1'b0};
  localparam out_beat_t WantLive = '{matched: 1'b0, dead: 1'b0};

  typedef struct packed {
    logic             wr_regs;
    logic             typed;
    op_e              op;
    logic [7:0]       idx;
    logic [63:0]      data;
    logic [7:0]       sym;
    logic             last;
    logic [63:0]      acc;
    out_beat_t        want;
  } dir_row_t;

  // register rows carry start_set in data and accept_set in acc
  localparam int DirRowCount = 28;
  localparam dir_row_t DirRows [DirRowCount] = '{
    '{1'b0, 1'b1, OP_MATCH,       8'h00, 64'h0,   8'h00, 1'b1, 64'h0,   WantDead},
    '{1'b0, 1'b1, OP_START,       8'h00, 64'h0,   8'h00, 1'b1, 64'h0,   WantDead},
    '{1'b1, 1'b0, OP_START,       8'h00, 64'h1,   8'h00, 1'b0, MaskTop, WantLive},
    '{1'b0, 1'b0, OP_LOAD_CLASS,  8'h61, 64'h1,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_CLASS,  8'h62, 64'h2,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_CLASS,  8'hff, MaskAll, 8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_CLASS,  8'h00, 64'h0,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_FOLLOW, 8'h00, 64'h2,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_FOLLOW, 8'h01, MaskTop, 8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_FOLLOW, 8'h3f, MaskTop, 8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_FOLLOW, 8'hff, 64'h0,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_FOLLOW, 8'h40, 64'h0,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_START,       8'h00, 64'h0,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_MATCH,       8'h00, 64'h0,   8'h61, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b1, OP_MATCH,       8'h00, 64'h0,   8'h62, 1'b1, 64'h0,   WantHit},
    '{1'b0, 1'b0, OP_START,       8'h00, 64'h0,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_MATCH,       8'h00, 64'h0,   8'h61, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b0, OP_LOAD_CLASS,  8'h62, 64'h0,   8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b1, OP_MATCH,       8'h00, 64'h0,   8'h62, 1'b1, 64'h0,   WantDead},
    '{1'b0, 1'b1, OP_MATCH,       8'h00, 64'h0,   8'hff, 1'b1, 64'h0,   WantDead},
    '{1'b1, 1'b0, OP_START,       8'h00, MaskAll, 8'h00, 1'b0, MaskAll, WantLive},
    '{1'b0, 1'b1, OP_START,       8'h00, 64'h0,   8'h00, 1'b1, 64'h0,   WantHit},
    '{1'b0, 1'b0, OP_MATCH,       8'h00, 64'h0,   8'hff, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b1, OP_MATCH,       8'h00, 64'h0,   8'h00, 1'b1, 64'h0,   WantDead},
    '{1'b1, 1'b0, OP_START,       8'h00, MaskAll, 8'h00, 1'b0, 64'h0,   WantLive},
    '{1'b0, 1'b1, OP_START,       8'h00, 64'h0,   8'h00, 1'b1, 64'h0,   WantLive},
    '{1'b1, 1'b0, OP_START,       8'h00, 64'h0,   8'h00, 1'b0, MaskAll, WantLive},
    '{1'b0, 1'b1, OP_START,       8'h00, 64'h0,   8'h00, 1'b1, 64'h0,   WantDead}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = CFG_START_SET;
  logic [MaskW-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_beat_t             in_beat_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_beat_t            out_beat_o;

  logic [63:0] class_rows [256];
  logic [63:0] follow_rows [64];
  logic [63:0] live_set = '0;
  logic [63:0] start_mask = '0;
  logic [63:0] accept_mask = '0;

  out_beat_t pending_results [$];
  out_beat_t oldest;
  int        mismatch_count = 0;
  int        beats_sent = 0;
  int        stall_left = 0;
  bit        quiet = 1'b0;

  nfa_position_set_matcher_unit #(
    .NUM_STATES(NumPos)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // table writes, next active set and end-of-string flags for one beat
  task automatic step_matcher(input in_beat_t b, output bit has_res, output out_beat_t res);
    logic [63:0] hit;
    logic [63:0] nxt;
    int p;
    has_res = 1'b0;
    res = '0;
    case (b.operation)
      OP_LOAD_CLASS: class_rows[b.table_index] = b.table_data;
      OP_LOAD_FOLLOW: begin
        if (b.table_index < NumPos) follow_rows[b.table_index[5:0]] = b.table_data;
      end
      OP_START: begin
        live_set = start_mask & PosMask;
        has_res = b.last;
      end
      default: begin
        if (live_set != '0) begin
          hit = live_set & class_rows[b.symbol] & PosMask;
          nxt = '0;
          for (p = 0; p < NumPos; p++) begin
            if (hit[p]) nxt |= follow_rows[p];
          end
          live_set = nxt & PosMask;
        end
        has_res = b.last;
      end
    endcase
    if (has_res) begin
      res.matched = |(live_set & accept_mask & PosMask);
      res.dead = ((live_set & PosMask) == '0);
    end
  endtask

  function automatic logic [63:0] pick_mask();
    logic [63:0] m;
    m = '0;
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = '1;
      2, 3: repeat ($urandom_range(1, 3)) m[$urandom_range(0, 63)] = 1'b1;
      4: m = {$urandom, $urandom};
      default: m = {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    return m;
  endfunction

  function automatic in_beat_t rand_beat(op_e op);
    in_beat_t b;
    b.operation = op;
    b.table_index = 8'($urandom_range(0, 255));
    b.table_data = pick_mask();
    b.symbol = 8'($urandom_range(0, 255));
    b.last = 1'($urandom_range(0, 1));
    if (op == OP_LOAD_FOLLOW && $urandom_range(0, 3) != 0)
      b.table_index = 8'($urandom_range(0, 63));
    return b;
  endfunction

  // entered and left at a falling edge; valid stays high on return
  task automatic send_beat(input in_beat_t b, input bit typed = 1'b0,
                           input out_beat_t want = '0);
    bit has_res;
    out_beat_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    step_matcher(b, has_res, res);
    if (has_res) pending_results.insert(pending_results.size(), typed ? want : res);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (NumPos + 8) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [63:0] s, input logic [63:0] a);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_START_SET;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_index_i <= CFG_ACCEPT_SET;
    cfg_wdata_i <= a;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    start_mask = s;
    accept_mask = a;
  endtask

  always @(negedge clk_i) begin
    if (quiet) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: expected nothing, got matched=%0b dead=%0b",
                 $time, out_beat_o.matched, out_beat_o.dead);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_beat_o !== oldest) begin
          $display("%0t: result mismatch: expected matched=%0b dead=%0b, got matched=%0b dead=%0b",
                   $time, oldest.matched, oldest.dead, out_beat_o.matched, out_beat_o.dead);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : main_seq
    int ph;
    int k;
    int len;
    int target;
    in_beat_t b;
    logic [7:0] alpha [4];
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every follow row gets a defined value before any string reads it
    // match bytes on a nonempty set only use class rows loaded beforehand
    for (k = 0; k < NumPos; k++) begin
      b = rand_beat(OP_LOAD_FOLLOW);
      b.table_index = 8'(k);
      send_beat(b);
    end

    for (k = 0; k < DirRowCount; k++) begin
      if (DirRows[k].wr_regs) begin
        settle();
        program_regs(DirRows[k].data, DirRows[k].acc);
      end else begin
        b.operation = DirRows[k].op;
        b.table_index = DirRows[k].idx;
        b.table_data = DirRows[k].data;
        b.symbol = DirRows[k].sym;
        b.last = DirRows[k].last;
        send_beat(b, DirRows[k].typed, DirRows[k].want);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      quiet = (ph >= 6);
      settle();
      program_regs((ph == 0) ? MaskAll : pick_mask(), (ph == 1) ? 64'h0 : pick_mask());
      for (k = 0; k < 4; k++) begin
        alpha[k] = 8'($urandom_range(0, 255));
        b = rand_beat(OP_LOAD_CLASS);
        b.table_index = alpha[k];
        send_beat(b);
      end
      repeat (8) begin
        b = rand_beat(OP_LOAD_FOLLOW);
        b.table_index = 8'($urandom_range(0, NumPos - 1));
        send_beat(b);
      end
      target = beats_sent + 24;
      while (beats_sent < target) begin
        case ($urandom_range(0, 9))
          7: send_beat(rand_beat(OP_LOAD_CLASS));
          8: send_beat(rand_beat(OP_LOAD_FOLLOW));
          9: begin
            b = rand_beat($urandom_range(0, 1) ? OP_START : OP_MATCH);
            b.symbol = alpha[$urandom_range(0, 3)];
            send_beat(b);
          end
          default: begin
            b = rand_beat(OP_START);
            b.last = ($urandom_range(0, 7) == 0);
            send_beat(b);
            if (!b.last) begin
              len = $urandom_range(1, 8);
              for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 11) == 0)
                  send_beat(rand_beat($urandom_range(0, 1) ? OP_LOAD_CLASS : OP_LOAD_FOLLOW));
                b = rand_beat(OP_MATCH);
                b.symbol = alpha[$urandom_range(0, 3)];
                b.last = (k == len - 1);
                send_beat(b);
              end
            end
          end
        endcase
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
